// ===== hw/rtl/vbc_pkg.sv =====
package vbc_pkg;

  // Input opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_CIPHER = 1'b1;

  // Register indexes, taken from paddr[2]
  localparam logic REG_KEY_LENGTH = 1'b0;
  localparam logic REG_DIRECTION  = 1'b1;

  localparam int KEYLEN_W = 7;
  localparam logic [KEYLEN_W-1:0] KEYLEN_RESET = 7'd1;
  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  // ASCII bounds and alphabet size
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_BIT     = 8'h20;
  localparam logic [7:0] ALPHA_SIZE   = 8'd26;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // One pending cipher word: text byte and the key character it uses
  typedef struct packed {
    logic [7:0] text;
    logic [7:0] key;
  } entry_t;

endpackage

// ===== hw/rtl/vigenere_byte_cipher_top.sv =====
// Vigenere byte cipher, case preserving, one word per clock sustained while
// out_stall stays low. A data word passes the key store read, the queue and
// the output register before reaching out_*; load words give no result.
// Unstalled: one word per cycle, set by the single key store read port.
// Reset (rst, synchronous): key position 0, key_length 1, direction encrypt,
// queue and output emptied; key store contents stay undefined until loaded.
module vigenere_byte_cipher_top #(
  parameter int KEY_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Input word channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic        first_of_message,
  input  logic [5:0]  key_slot,
  input  logic [7:0]  data_byte,
  // Result word channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [vbc_pkg::KEYLEN_W-1:0] key_length;
  logic                         direction;
  logic                         cfg_write;
  logic                         push;
  vbc_pkg::entry_t              push_entry;
  logic                         pop;
  vbc_pkg::entry_t              head;
  logic                         empty;
  logic [vbc_pkg::QCNT_W-1:0]   queue_level;

  // Registers are word addressed; paddr[2] picks the register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= vbc_pkg::KEYLEN_RESET;
      direction  <= vbc_pkg::DIR_ENCRYPT;
    end else if (cfg_write) begin
      unique case (paddr[2])
        vbc_pkg::REG_KEY_LENGTH: key_length <= pwdata[vbc_pkg::KEYLEN_W-1:0];
        vbc_pkg::REG_DIRECTION:  direction  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      vbc_pkg::REG_KEY_LENGTH: prdata = 32'(key_length);
      vbc_pkg::REG_DIRECTION:  prdata = 32'(direction);
      default:                 prdata = '0;
    endcase
  end

  // Front: accept words, write key loads, track the key position and
  // fetch the key character for each data word
  vbc_front #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .first_of_message (first_of_message),
    .key_slot         (key_slot),
    .data_byte        (data_byte),
    .key_length       (key_length),
    .queue_level      (queue_level),
    .push             (push),
    .push_entry       (push_entry)
  );

  // Short queue decouples the front from output backpressure
  vbc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .level      (queue_level)
  );

  // Back: shift the text letter and hold it in the output register
  vbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .direction (direction),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte)
  );

endmodule

// ===== hw/rtl/vbc_ram.sv =====
module vbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/vbc_front.sv =====
module vbc_front #(
  parameter int KEY_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic                          first_of_message,
  input  logic [5:0]                    key_slot,
  input  logic [7:0]                    data_byte,
  input  logic [vbc_pkg::KEYLEN_W-1:0]  key_length,
  input  logic [vbc_pkg::QCNT_W-1:0]    queue_level,
  output logic                          push,
  output vbc_pkg::entry_t               push_entry
);

  localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int LW = (AW + 1 > vbc_pkg::KEYLEN_W) ? AW + 1 : vbc_pkg::KEYLEN_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(KEY_DEPTH);

  logic          accept;
  logic [AW-1:0] key_position;
  logic [AW-1:0] key_position_next;
  logic [LW-1:0] len_ext;
  logic [LW-1:0] len_eff;
  logic [LW-1:0] pos_ext;
  logic [AW-1:0] pos_use;
  logic [LW-1:0] pos_inc;
  logic [LW-1:0] slot_ext;
  logic          load_we;
  logic [AW-1:0] load_addr;
  logic [7:0]    key_char;
  logic          s1_valid;
  logic [7:0]    s1_text;

  function automatic logic [vbc_pkg::QCNT_W:0] QCNT_W_EXT(
      input logic [vbc_pkg::QCNT_W-1:0] v);
    QCNT_W_EXT = {1'b0, v};
  endfunction

  // Hold off while the queue could not take the word already in flight
  assign in_stall = (QCNT_W_EXT(queue_level) + QCNT_W_EXT({2'b00, s1_valid}))
                    >= QCNT_W_EXT(vbc_pkg::QCNT_W'(vbc_pkg::QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    len_ext = LW'(key_length);
    if (len_ext == '0) begin
      len_eff = LW'(1);
    end else if (len_ext > DEPTH_L) begin
      len_eff = DEPTH_L;
    end else begin
      len_eff = len_ext;
    end
    pos_ext = LW'(key_position);
    if (first_of_message || pos_ext >= len_eff) begin
      pos_use = '0;
    end else begin
      pos_use = key_position;
    end
    pos_inc = LW'(pos_use) + LW'(1);
    if (pos_inc >= len_eff) begin
      key_position_next = '0;
    end else begin
      key_position_next = pos_inc[AW-1:0];
    end
  end

  // Drop loads aimed past the end of the store
  assign slot_ext  = LW'(key_slot);
  assign load_addr = slot_ext[AW-1:0];
  assign load_we   = accept && (opcode == vbc_pkg::OP_LOAD) && (slot_ext < DEPTH_L);

  vbc_ram #(
    .WIDTH (8),
    .DEPTH (KEY_DEPTH)
  ) u_key_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_addr),
    .wdata (data_byte),
    .raddr (pos_use),
    .rdata (key_char)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_position <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept && (opcode == vbc_pkg::OP_CIPHER);
      if (accept && (opcode == vbc_pkg::OP_CIPHER)) begin
        key_position <= key_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_text <= data_byte;
    end
  end

  assign push            = s1_valid;
  assign push_entry.text = s1_text;
  assign push_entry.key  = key_char;

endmodule

// ===== hw/rtl/vbc_queue.sv =====
module vbc_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  vbc_pkg::entry_t             push_entry,
  input  logic                        pop,
  output vbc_pkg::entry_t             head,
  output logic                        empty,
  output logic [vbc_pkg::QCNT_W-1:0]  level
);

  vbc_pkg::entry_t             slots [vbc_pkg::QUEUE_DEPTH];
  logic [vbc_pkg::QPTR_W-1:0]  wr_ptr;
  logic [vbc_pkg::QPTR_W-1:0]  rd_ptr;
  logic [vbc_pkg::QCNT_W-1:0]  count;
  logic [vbc_pkg::QCNT_W-1:0]  count_next;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + vbc_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - vbc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + vbc_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + vbc_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign level = count;

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < vbc_pkg::QCNT_W'(vbc_pkg::QUEUE_DEPTH))
    else $error("queue push while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue pop while empty");

  a_ptr_match : assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == vbc_pkg::QCNT_W'(vbc_pkg::QUEUE_DEPTH)) |->
      wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");

endmodule

// ===== hw/rtl/vbc_back.sv =====
module vbc_back (
  input  logic            clk,
  input  logic            rst,
  input  vbc_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  input  logic            direction,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte
);

  localparam logic signed [9:0] WRAP = $signed({2'b00, vbc_pkg::ALPHA_SIZE});
  localparam logic signed [9:0] LAST = WRAP - 10'sd1;

  logic              x_upper;
  logic              x_lower;
  logic              y_upper;
  logic              y_lower;
  logic [7:0]        y;
  logic [7:0]        base;
  logic signed [9:0] xs;
  logic signed [9:0] ys;
  logic signed [9:0] bs;
  logic signed [9:0] t;
  logic [7:0]        result;

  always_comb begin
    x_upper = (head.text >= vbc_pkg::CHAR_UPPER_A) && (head.text <= vbc_pkg::CHAR_UPPER_Z);
    x_lower = (head.text >= vbc_pkg::CHAR_LOWER_A) && (head.text <= vbc_pkg::CHAR_LOWER_Z);
    y_upper = (head.key >= vbc_pkg::CHAR_UPPER_A) && (head.key <= vbc_pkg::CHAR_UPPER_Z);
    y_lower = (head.key >= vbc_pkg::CHAR_LOWER_A) && (head.key <= vbc_pkg::CHAR_LOWER_Z);
    // Give a letter key the text's case
    if ((x_upper && y_lower) || (!x_upper && y_upper)) begin
      y = head.key ^ vbc_pkg::CASE_BIT;
    end else begin
      y = head.key;
    end
    base = x_upper ? vbc_pkg::CHAR_UPPER_A : vbc_pkg::CHAR_LOWER_A;
    xs   = $signed({2'b00, head.text});
    ys   = $signed({2'b00, y});
    bs   = $signed({2'b00, base});
    if (direction == vbc_pkg::DIR_ENCRYPT) begin
      t = ys + (xs - bs);
      if (t > bs + LAST) begin
        t = t - WRAP;
      end
    end else begin
      t = xs + (bs - ys);
      if (t < bs) begin
        t = t + WRAP;
      end
    end
    if (x_upper || x_lower) begin
      result = t[7:0];
    end else begin
      result = head.text;
    end
  end

  assign pop = !empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte <= result;
    end
  end

endmodule

// ===== sim/vigenere_byte_cipher_top_tb.sv =====
module vigenere_byte_cipher_top_tb;

  localparam int KEY_SLOTS     = 64;
  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 7;
  // Allow the slowest legal run several times over
  localparam int LIMIT_CYCLES  = 600000;
  localparam int LONG_HOLD     = 120;
  // Trailing load words leave no trace at the output, so idle after draining
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_WORDS   = 130;

  typedef struct {
    logic       op;
    logic       first;
    logic [5:0] slot;
    logic [7:0] value;
  } cipher_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = vbc_pkg::OP_LOAD;
  logic        first_of_message = 1'b0;
  logic [5:0]  key_slot = '0;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  vigenere_byte_cipher_top #(
    .KEY_DEPTH(KEY_SLOTS)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .first_of_message (first_of_message),
    .key_slot         (key_slot),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cipher predictor: own copy of the key store, key position and registers.
  // ---------------------------------------------------------------------------
  logic [7:0]                   key_copy [KEY_SLOTS];
  int unsigned                  key_pos = 0;
  logic [vbc_pkg::KEYLEN_W-1:0] len_reg = vbc_pkg::KEYLEN_RESET;
  logic                         dir_reg = vbc_pkg::DIR_ENCRYPT;
  logic [7:0]                   expected_bytes [$];

  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  // Clamp the key length register to the usable range: zero acts as one,
  // anything past the store depth saturates.
  function automatic int unsigned active_len(logic [vbc_pkg::KEYLEN_W-1:0] cfg);
    if (cfg == 0) return 1;
    if (cfg > KEY_SLOTS) return KEY_SLOTS;
    return 32'(cfg);
  endfunction

  function automatic bit is_upper(logic [7:0] c);
    return c >= vbc_pkg::CHAR_UPPER_A && c <= vbc_pkg::CHAR_UPPER_Z;
  endfunction

  function automatic bit is_lower(logic [7:0] c);
    return c >= vbc_pkg::CHAR_LOWER_A && c <= vbc_pkg::CHAR_LOWER_Z;
  endfunction

  // Shift one text byte by one key character. Non-letters pass through; a
  // letter key takes the text letter's case, any other key is used raw and
  // the sum simply wraps at 8 bits.
  function automatic logic [7:0] shift_letter(logic [7:0] text, logic [7:0] key, logic dir);
    bit         up;
    int         base;
    int         sum;
    logic [7:0] k;
    up = is_upper(text);
    if (!up && !is_lower(text)) return text;
    k = key;
    if ((up && is_lower(key)) || (!up && is_upper(key))) k = key ^ vbc_pkg::CASE_BIT;
    base = up ? int'(vbc_pkg::CHAR_UPPER_A) : int'(vbc_pkg::CHAR_LOWER_A);
    if (dir == vbc_pkg::DIR_ENCRYPT) begin
      sum = int'(k) + int'(text) - base;
      if (sum > base + int'(vbc_pkg::ALPHA_SIZE) - 1) sum -= int'(vbc_pkg::ALPHA_SIZE);
    end else begin
      sum = int'(text) + base - int'(k);
      if (sum < base) sum += int'(vbc_pkg::ALPHA_SIZE);
    end
    return sum[7:0];
  endfunction

  // Advance the predictor by one accepted word; a cipher word queues its byte.
  function automatic void apply_word(logic op, logic first, logic [5:0] slot,
                                     logic [7:0] value);
    int unsigned len;
    int unsigned pos;
    if (op == vbc_pkg::OP_LOAD) begin
      key_copy[slot] = value;
      return;
    end
    len = active_len(len_reg);
    pos = key_pos;
    // Restart at slot zero on a new message or when the key was shortened
    // underneath the current position
    if (first || pos >= len) pos = 0;
    expected_bytes.push_back(shift_letter(value, key_copy[pos], dir_reg));
    pos++;
    if (pos >= len) pos = 0;
    key_pos = pos;
  endfunction

  function automatic void flag_error(string what, logic [7:0] want, logic [7:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("ERROR %s: expected %02h, got %02h", what, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Record input acceptance
  // for the sender, predict on every accepted input word, and check every
  // accepted output word against the oldest prediction.
  // ---------------------------------------------------------------------------
  logic in_taken = 1'b0;

  always @(posedge clk) begin : monitor
    logic [7:0] want;
    in_taken <= in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall)
        apply_word(opcode, first_of_message, key_slot, data_byte);
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          flag_error("unexpected out_byte", 'x, out_byte);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want) flag_error("out_byte", want, out_byte);
        end
      end
    end
  end

  // Watchdog: a hang or a lost word ends the run here
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: present queued words at the falling edge. Hold the payload while
  // stalled; after each accepted word insert a random gap unless gaps are off.
  // ---------------------------------------------------------------------------
  cipher_word_t pending_words [$];
  bit           tx_gaps_on = 1'b1;
  int unsigned  tx_gap = 0;

  // Mostly back to back, often a short pause, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin : sender
    cipher_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tx_gap != 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        opcode           <= w.op;
        first_of_message <= w.first;
        key_slot         <= w.slot;
        data_byte        <= w.value;
        in_valid         <= 1'b1;
        tx_gap = tx_gaps_on ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  // The hold is counted here so the sender keeps pushing and the block backs up.
  // ---------------------------------------------------------------------------
  bit          rx_gaps_on = 1'b1;
  int unsigned rx_wait = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_served = 0;

  always @(negedge clk) begin : receiver
    if (hold_served != hold_reqs) begin
      hold_served = hold_reqs;
      rx_wait = LONG_HOLD;
    end else if (rx_wait == 0 && rx_gaps_on) begin
      rx_wait = pick_gap();
    end
    if (rx_wait != 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  bit         slot_loaded [KEY_SLOTS];
  logic [7:0] corner_text [11];

  function automatic void queue_load(int unsigned slot, logic [7:0] value);
    cipher_word_t w;
    w.op    = vbc_pkg::OP_LOAD;
    w.first = 1'($urandom_range(0, 1));
    w.slot  = 6'(slot);
    w.value = value;
    pending_words.push_back(w);
    slot_loaded[slot] = 1'b1;
  endfunction

  function automatic void queue_data(logic first, logic [7:0] value);
    cipher_word_t w;
    w.op    = vbc_pkg::OP_CIPHER;
    w.first = first;
    w.slot  = 6'($urandom_range(0, KEY_SLOTS - 1));
    w.value = value;
    pending_words.push_back(w);
  endfunction

  // Mostly letters of both cases, then printable text, the characters just
  // outside each letter range, and any byte at all
  function automatic logic [7:0] random_text_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return vbc_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 25));
    if (r < 60) return vbc_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25));
    if (r < 80) return 8'($urandom_range(32, 126));
    if (r < 88) begin
      case ($urandom_range(0, 3))
        0:       return vbc_pkg::CHAR_UPPER_A - 8'd1;
        1:       return vbc_pkg::CHAR_UPPER_Z + 8'd1;
        2:       return vbc_pkg::CHAR_LOWER_A - 8'd1;
        default: return vbc_pkg::CHAR_LOWER_Z + 8'd1;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] random_key_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return vbc_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 25));
    if (r < 90) return vbc_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  // Register write: setup cycle, access cycle, written at the edge with pready
  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == vbc_pkg::REG_KEY_LENGTH) len_reg = value[vbc_pkg::KEYLEN_W-1:0];
    else dir_reg = value[0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold until every queued word is taken and every predicted byte is back,
  // then let the pipeline settle (trailing load words leave no result)
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers change only with the block idle
  task automatic set_mode(logic [vbc_pkg::KEYLEN_W-1:0] len_cfg, logic dir);
    wait_drained();
    write_reg(vbc_pkg::REG_KEY_LENGTH, 32'(len_cfg));
    write_reg(vbc_pkg::REG_DIRECTION, 32'(dir));
  endtask

  // One random phase: new settings, load any slot the key may reach that was
  // never loaded, then a stream of messages with stray key loads and the odd
  // start flag out of place
  task automatic run_phase(logic [vbc_pkg::KEYLEN_W-1:0] len_cfg, logic dir,
                           int unsigned n_data, bit gaps, bit long_hold);
    int unsigned len;
    int unsigned sent;
    int unsigned msg_len;
    logic        msg_first;
    set_mode(len_cfg, dir);
    tx_gaps_on = gaps && !long_hold;
    rx_gaps_on = gaps;
    len = active_len(len_cfg);
    for (int unsigned s = 0; s < len; s++)
      if (!slot_loaded[s]) queue_load(s, random_key_byte());
    if (long_hold) hold_reqs++;
    sent = 0;
    // Half the phases pick up the key position left by the previous one
    msg_first = 1'($urandom_range(0, 1));
    while (sent < n_data) begin
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                            : $urandom_range(1, 30);
      for (int unsigned i = 0; i < msg_len && sent < n_data; i++) begin
        if ($urandom_range(0, 19) == 0)
          queue_load($urandom_range(0, KEY_SLOTS - 1), random_key_byte());
        queue_data((i == 0) ? msg_first : ($urandom_range(0, 49) == 0), random_text_byte());
        sent++;
      end
      // A few messages run on without a start flag
      msg_first = ($urandom_range(0, 9) != 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    corner_text = '{vbc_pkg::CHAR_UPPER_A, vbc_pkg::CHAR_UPPER_Z,
                    vbc_pkg::CHAR_LOWER_A, vbc_pkg::CHAR_LOWER_Z,
                    vbc_pkg::CHAR_UPPER_A - 8'd1, vbc_pkg::CHAR_UPPER_Z + 8'd1,
                    vbc_pkg::CHAR_LOWER_A - 8'd1, vbc_pkg::CHAR_LOWER_Z + 8'd1,
                    8'h00, 8'hFF, 8'h80};
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed: a three-character key of a lowercase letter, an uppercase
    // letter and a non-letter, so each case rule and the raw 8-bit wrap show
    // up on the letter bounds, their neighbors and the high bytes
    set_mode(7'd3, vbc_pkg::DIR_ENCRYPT);
    queue_load(0, vbc_pkg::CHAR_LOWER_Z);
    queue_load(1, "B");
    queue_load(2, 8'hFF);
    queue_load(KEY_SLOTS - 1, "q");
    foreach (corner_text[i]) queue_data(i == 0, corner_text[i]);
    set_mode(7'd3, vbc_pkg::DIR_DECRYPT);
    for (int i = 0; i < 5; i++) queue_data(i == 0, corner_text[i]);
    // Key position now sits at slot two: shorten the key beneath it
    set_mode(7'd2, vbc_pkg::DIR_DECRYPT);
    queue_data(1'b0, "m");

    // Random phases over the register extremes, zero and saturating lengths
    // included; two phases hold the output off for a long stretch and at least two
    // run with no idling at all
    run_phase(7'd5,   vbc_pkg::DIR_ENCRYPT, PHASE_WORDS, 1'b1, 1'b0);
    run_phase(7'd64,  vbc_pkg::DIR_DECRYPT, PHASE_WORDS, 1'b1, 1'b1);
    run_phase(7'd2,   vbc_pkg::DIR_ENCRYPT, PHASE_WORDS, 1'b0, 1'b0);
    run_phase(7'd0,   vbc_pkg::DIR_DECRYPT, PHASE_WORDS, 1'b1, 1'b0);
    run_phase(7'd127, vbc_pkg::DIR_ENCRYPT, PHASE_WORDS, 1'b1, 1'b0);
    run_phase(7'd1,   vbc_pkg::DIR_ENCRYPT, PHASE_WORDS, 1'b1, 1'b0);
    run_phase(7'd65,  vbc_pkg::DIR_DECRYPT, PHASE_WORDS, 1'b0, 1'b0);
    run_phase(7'd33,  vbc_pkg::DIR_DECRYPT, PHASE_WORDS, 1'b1, 1'b1);
    repeat (4)
      run_phase(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), PHASE_WORDS,
                $urandom_range(0, 3) != 0, 1'b0);

    wait_drained();
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/vbc_pkg.sv
hw/rtl/vbc_ram.sv
hw/rtl/vbc_front.sv
hw/rtl/vbc_queue.sv
hw/rtl/vbc_back.sv
hw/rtl/vigenere_byte_cipher_top.sv
sim/vigenere_byte_cipher_top_tb.sv
